FILE: hw/rtl/swpp_pkg.sv
package swpp_pkg;

	// Table and image limits.
	localparam int TABLE_ENTRIES = 1024;
	localparam int TABLE_BITS    = $clog2(TABLE_ENTRIES);
	localparam int QUARTER       = TABLE_ENTRIES / 4;
	localparam int QUARTER_BITS  = TABLE_BITS - 2;
	localparam int MAX_COLUMNS   = 2048;
	localparam int MAX_ROWS      = 1024;

	// Field and register widths.
	localparam int WL_W      = 12;
	localparam int SPEED_W   = 11;
	localparam int AMP_W     = 10;
	localparam int MID_W     = 10;
	localparam int IW_W      = 12;
	localparam int IH_W      = 11;
	localparam int COL_W     = 11;
	localparam int FRAME_W   = 10;
	localparam int ROW_W     = 12;
	localparam int ADDR_W    = 21;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 3;

	// Datapath widths.
	localparam int PROD_W    = SPEED_W + FRAME_W + 1;
	localparam int POS_W     = PROD_W;
	localparam int MAG_W     = POS_W - 1;
	localparam int SINE_W    = 16;
	localparam int FRAC_BITS = 15;
	localparam int NUM_W     = MID_W + FRAC_BITS + 2;

	// Long division of {|pos|, fraction bits} by the wavelength.
	localparam int DIV_PER_STAGE = 4;
	localparam int DIV_STAGES    = (MAG_W + TABLE_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
	localparam int DIV_W         = DIV_STAGES * DIV_PER_STAGE;
	localparam int DIV_PAD       = DIV_W - MAG_W - TABLE_BITS;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WAVELENGTH   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SPEED        = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_ROW   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(5);

	// Register reset values.
	localparam logic [WL_W-1:0]           RST_WAVELENGTH   = WL_W'(100);
	localparam logic signed [SPEED_W-1:0] RST_SPEED        = '0;
	localparam logic [AMP_W-1:0]          RST_AMPLITUDE    = AMP_W'(266);
	localparam logic [MID_W-1:0]          RST_MIDDLE_ROW   = MID_W'(400);
	localparam logic [IW_W-1:0]           RST_IMAGE_WIDTH  = IW_W'(1400);
	localparam logic [IH_W-1:0]           RST_IMAGE_HEIGHT = IH_W'(800);

	// Effective configuration seen by the datapath.
	typedef struct packed {
		logic [WL_W-1:0]           wavelength;
		logic signed [SPEED_W-1:0] speed;
		logic [AMP_W-1:0]          amplitude;
		logic [MID_W-1:0]          middle_row;
		logic [IW_W-1:0]           width;
		logic [IH_W-1:0]           height;
	} cfg_t;

	// Request state inside the divider pipeline.
	typedef struct packed {
		logic [COL_W-1:0]      column;
		logic                  neg;
		logic [DIV_W-1:0]      dvd;
		logic [WL_W-1:0]       rem;
		logic [TABLE_BITS-1:0] quo;
	} div_t;

	typedef logic [SINE_W-2:0] sine_rom_t [QUARTER];

	// First-quadrant sine magnitude in Q0.15 for table index m in [0, QUARTER].
	// Q30 Taylor series up to the 13th power, rounded half up, saturated.
	function automatic logic [SINE_W-2:0] sine_mag(input logic [63:0] m);
		logic [63:0] frac;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] sum_pos;
		logic [63:0] sum_neg;
		logic [63:0] v;
		frac    = (m << 32) / 64'(TABLE_ENTRIES);
		a       = (frac * 64'd1686629713) >> 30;
		a2      = (a * a) >> 30;
		term    = a;
		sum_pos = a;
		term    = ((term * a2) >> 30) / 64'd6;
		sum_neg = term;
		term    = ((term * a2) >> 30) / 64'd20;
		sum_pos = sum_pos + term;
		term    = ((term * a2) >> 30) / 64'd42;
		sum_neg = sum_neg + term;
		term    = ((term * a2) >> 30) / 64'd72;
		sum_pos = sum_pos + term;
		term    = ((term * a2) >> 30) / 64'd110;
		sum_neg = sum_neg + term;
		term    = ((term * a2) >> 30) / 64'd156;
		sum_pos = sum_pos + term;
		v = (sum_pos > sum_neg) ? (sum_pos - sum_neg) : 64'd0;
		v = (v + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[SINE_W-2:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int i = 0; i < QUARTER; i++) begin
			rom[i] = sine_mag(64'(i));
		end
		return rom;
	endfunction

	// Quarter-wave table plus the peak entry at a quarter cycle.
	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam logic [SINE_W-2:0] SINE_PEAK = sine_mag(64'(QUARTER));

endpackage

FILE: hw/rtl/swpp_front.sv
module swpp_front
	import swpp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [SPEED_W-1:0] speed,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [COL_W-1:0]          column,
	input  logic [FRAME_W-1:0]        frame_index,
	output logic                      out_valid,
	input  logic                      out_stall,
	output div_t                      out_data
);

	logic                     valid_s1;
	logic [COL_W-1:0]         col_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     valid_s2;
	div_t                     data_s2;

	logic                     rdy1;
	logic                     rdy2;
	logic signed [POS_W-1:0]  pos_c;
	logic [MAG_W-1:0]         mag_c;

	// A stage loads when it is empty or its successor moves on.
	assign rdy2     = !valid_s2 || !out_stall;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	// Stage 1: shift per frame times frame number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			col_s1  <= column;
			prod_s1 <= speed * $signed({1'b0, frame_index});
		end
	end

	// Stage 2: position, its sign and magnitude as the dividend.
	assign pos_c = $signed(POS_W'(col_s1)) - prod_s1;
	assign mag_c = pos_c[POS_W-1] ? MAG_W'(-pos_c) : MAG_W'(pos_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			data_s2.column <= col_s1;
			data_s2.neg    <= pos_c[POS_W-1];
			data_s2.dvd    <= {{DIV_PAD{1'b0}}, mag_c, {TABLE_BITS{1'b0}}};
			data_s2.rem    <= '0;
			data_s2.quo    <= '0;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

FILE: hw/rtl/swpp_div_stage.sv
module swpp_div_stage
	import swpp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [WL_W-1:0] wavelength,
	input  logic            in_valid,
	output logic            in_stall,
	input  div_t            in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output div_t            out_data
);

	logic valid_s1;
	div_t data_s1;
	logic rdy;
	div_t next_c;

	assign rdy      = !valid_s1 || !out_stall;
	assign in_stall = !rdy;

	// Restoring division steps: shift in one dividend bit, subtract when it fits.
	always_comb begin
		logic [WL_W:0] sh;
		next_c = in_data;
		for (int i = 0; i < DIV_PER_STAGE; i++) begin
			sh         = {next_c.rem, next_c.dvd[DIV_W-1]};
			next_c.dvd = {next_c.dvd[DIV_W-2:0], 1'b0};
			if (sh >= {1'b0, wavelength}) begin
				next_c.rem = WL_W'(sh - {1'b0, wavelength});
				next_c.quo = {next_c.quo[TABLE_BITS-2:0], 1'b1};
			end else begin
				next_c.rem = sh[WL_W-1:0];
				next_c.quo = {next_c.quo[TABLE_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && in_valid) begin
			data_s1 <= next_c;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

FILE: hw/rtl/swpp_back.sv
module swpp_back
	import swpp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  div_t              in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ROW_W-1:0]  row,
	output logic              inside_res,
	output logic [ADDR_W-1:0] pixel_address
);

	logic                     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic                     rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [TABLE_BITS-1:0]    idx_s1;
	logic [COL_W-1:0]         col_s1, col_s2, col_s3, col_s4;
	logic signed [SINE_W-1:0] sine_s2;
	logic signed [NUM_W-1:0]  num_s3;
	logic [ROW_W-1:0]         row_s4, row_s5;
	logic                     inside_s4, inside_s5;
	logic [ADDR_W-1:0]        addr_s5;

	logic [TABLE_BITS-1:0]    quo_adj_c;
	logic [TABLE_BITS-1:0]    idx_c;
	logic [1:0]               quad_c;
	logic [QUARTER_BITS:0]    mirror_c;
	logic [SINE_W-2:0]        mag_c;
	logic signed [SINE_W-1:0] sine_c;
	logic signed [NUM_W-1:0]  mid_c;
	logic signed [NUM_W-1:0]  prod_c;
	logic [NUM_W-1:0]         abs_num_c;
	logic [ROW_W-1:0]         row_mag_c;
	logic [ROW_W-1:0]         row_c;
	logic                     inside_c;
	logic [ADDR_W+1:0]        addr_c;

	// Ready chain from the output register back to the entry.
	assign rdy5     = !valid_s5 || !out_stall;
	assign rdy4     = !valid_s4 || rdy5;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Stage 1: table index. A negative position takes the complement of the
	// rounded-up quotient, which gives the floor modulo phase.
	assign quo_adj_c = in_data.quo + TABLE_BITS'(in_data.rem != '0);
	assign idx_c     = in_data.neg ? TABLE_BITS'(-quo_adj_c) : in_data.quo;

	// Stage 2: quarter-wave lookup with mirror and sign.
	assign quad_c   = idx_s1[TABLE_BITS-1:TABLE_BITS-2];
	assign mirror_c = quad_c[0]
		? (QUARTER_BITS + 1)'(QUARTER) - {1'b0, idx_s1[QUARTER_BITS-1:0]}
		: {1'b0, idx_s1[QUARTER_BITS-1:0]};
	assign mag_c    = mirror_c[QUARTER_BITS] ? SINE_PEAK
		: SINE_ROM[mirror_c[QUARTER_BITS-1:0]];
	assign sine_c   = quad_c[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

	// Stage 3: middle row in Q15 minus amplitude times sine.
	assign mid_c  = $signed({{(NUM_W - MID_W - FRAC_BITS){1'b0}}, cfg.middle_row,
		{FRAC_BITS{1'b0}}});
	assign prod_c = $signed({1'b0, cfg.amplitude}) * sine_s2;

	// Stage 4: truncate toward zero and check bounds.
	assign abs_num_c = num_s3[NUM_W-1] ? NUM_W'(-num_s3) : NUM_W'(num_s3);
	assign row_mag_c = abs_num_c[NUM_W-1:FRAC_BITS];
	assign row_c     = num_s3[NUM_W-1] ? ROW_W'(-row_mag_c) : row_mag_c;
	assign inside_c  = ({1'b0, col_s3} < cfg.width) && !row_c[ROW_W-1]
		&& (row_c[IH_W-1:0] < cfg.height);

	// Stage 5: row-major address; a row inside the image fits in ten bits.
	assign addr_c = (ADDR_W + 2)'(row_s4[9:0]) * (ADDR_W + 2)'(cfg.width)
		+ (ADDR_W + 2)'(col_s4);

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			idx_s1 <= idx_c;
			col_s1 <= in_data.column;
		end
		if (rdy2 && valid_s1) begin
			sine_s2 <= sine_c;
			col_s2  <= col_s1;
		end
		if (rdy3 && valid_s2) begin
			num_s3 <= mid_c - prod_c;
			col_s3 <= col_s2;
		end
		if (rdy4 && valid_s3) begin
			row_s4    <= row_c;
			inside_s4 <= inside_c;
			col_s4    <= col_s3;
		end
		if (rdy5 && valid_s4) begin
			row_s5    <= row_s4;
			inside_s5 <= inside_s4;
			addr_s5   <= inside_s4 ? addr_c[ADDR_W-1:0] : '0;
		end
	end

	assign out_valid     = valid_s5;
	assign row           = row_s5;
	assign inside_res    = inside_s5;
	assign pixel_address = addr_s5;

endmodule

FILE: hw/rtl/sine_wave_pixel_plotter_unit.sv
// Throughput: one request per cycle while the output is not stalled; the eight-stage
// divider (four quotient bits per stage) and the three multipliers are fully pipelined.
// Each stage loads when it is empty or its successor moves on, so bubbles close up under output stall.
// Reset: all pipeline stages empty and the registers at their default values.
module sine_wave_pixel_plotter_unit
	import swpp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COL_W-1:0]     column,
	input  logic [FRAME_W-1:0]   frame_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ROW_W-1:0]     row,
	output logic                 inside_res,
	output logic [ADDR_W-1:0]    pixel_address
);

	logic [WL_W-1:0]           wavelength_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic [AMP_W-1:0]          amplitude_q;
	logic [MID_W-1:0]          middle_row_q;
	logic [IW_W-1:0]           image_width_q;
	logic [IH_W-1:0]           image_height_q;

	cfg_t cfg;
	div_t div_data  [DIV_STAGES+1];
	logic div_valid [DIV_STAGES+1];
	logic div_stall [DIV_STAGES+1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wavelength_q   <= RST_WAVELENGTH;
			speed_q        <= RST_SPEED;
			amplitude_q    <= RST_AMPLITUDE;
			middle_row_q   <= RST_MIDDLE_ROW;
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WAVELENGTH:   wavelength_q   <= cfg_data[WL_W-1:0];
				REG_SPEED:        speed_q        <= $signed(cfg_data[SPEED_W-1:0]);
				REG_AMPLITUDE:    amplitude_q    <= cfg_data[AMP_W-1:0];
				REG_MIDDLE_ROW:   middle_row_q   <= cfg_data[MID_W-1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IW_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[IH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective settings: a zero wavelength acts as one, the image is clamped.
	assign cfg.wavelength = (wavelength_q == '0) ? WL_W'(1) : wavelength_q;
	assign cfg.speed      = speed_q;
	assign cfg.amplitude  = amplitude_q;
	assign cfg.middle_row = middle_row_q;
	assign cfg.width      = (image_width_q > IW_W'(MAX_COLUMNS)) ? IW_W'(MAX_COLUMNS)
		: image_width_q;
	assign cfg.height     = (image_height_q > IH_W'(MAX_ROWS)) ? IH_W'(MAX_ROWS)
		: image_height_q;

	swpp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.speed       (cfg.speed),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.column      (column),
		.frame_index (frame_index),
		.out_valid   (div_valid[0]),
		.out_stall   (div_stall[0]),
		.out_data    (div_data[0])
	);

	// Divider pipeline: remainder of the position, then the table index.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		swpp_div_stage u_div (
			.clk        (clk),
			.arst_n     (arst_n),
			.wavelength (cfg.wavelength),
			.in_valid   (div_valid[g]),
			.in_stall   (div_stall[g]),
			.in_data    (div_data[g]),
			.out_valid  (div_valid[g+1]),
			.out_stall  (div_stall[g+1]),
			.out_data   (div_data[g+1])
		);
	end

	swpp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (div_valid[DIV_STAGES]),
		.in_stall      (div_stall[DIV_STAGES]),
		.in_data       (div_data[DIV_STAGES]),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.row           (row),
		.inside_res    (inside_res),
		.pixel_address (pixel_address)
	);

endmodule

FILE: hw/rtl/swpp_checker.sv
module swpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] row,
	input logic        inside_res,
	input logic [20:0] pixel_address
);

	// A result held under stall stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A result held under stall keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(row) && $stable(inside_res)
			&& $stable(pixel_address))
		else $error("stalled result changed");

	// With the output free, every stage can move, so the input is never stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	// A pixel outside the image reports address zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_res |-> pixel_address == 21'd0)
		else $error("nonzero address for outside pixel");

	// A pixel inside the image has a nonnegative row.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_res |-> !row[11])
		else $error("negative row marked inside");

endmodule

bind sine_wave_pixel_plotter_unit swpp_checker u_checker (.*);
